// ===== hdl/ffca_pkg.sv =====
// Shared types, codes and constants of the first-fit coalescing allocator.
package ffca_pkg;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 32;
    localparam int ADJ_W      = 13;
    localparam int ALU_W      = 33;
    localparam int OP_W       = 2;
    localparam int LG_W       = 4;
    localparam int STAT_W     = 2;
    localparam int LIVE_OUT_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int ALIGN_MAX  = 12;

    localparam int DEF_FREE_SLOTS   = 16;
    localparam int DEF_RECORD_SLOTS = 16;
    localparam int DEF_HEADER_BYTES = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd0;
    localparam logic [LEN_W-1:0]  POOL_SIZE_RST = 32'd65536;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_UNKNOWN = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [4:0] {
        S_BOOT, S_IDLE,
        S_A_CHK, S_A_REC, S_A_RD, S_A_ADJ, S_A_TOT, S_A_CMP, S_A_REM, S_A_GRANT, S_A_USED,
        S_SH_RD, S_SH_WR,
        S_F_RREQ, S_F_RCHK, S_F_BST, S_F_BEND, S_F_PRD, S_F_PCHK, S_F_LO, S_F_MRG, S_F_M2,
        S_I_RD, S_I_WR, S_F_FIN,
        S_INIT, S_DONE
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [LEN_W-1:0]  size;
        logic [LG_W-1:0]   lg;
        logic [ADDR_W-1:0] addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]     granted;
        t_status               status;
        logic [LEN_W-1:0]      used;
        logic [LIVE_OUT_W-1:0] live;
    } t_rsp;

endpackage

// ===== hdl/first_fit_coalescing_allocator.sv =====
// Top level of the first-fit coalescing allocator: config registers and result register.
// Usage:
//   Requests enter on the input channel (i_in_valid / o_in_stall) with an opcode:
//   allocate (request_size, align_log2), free (address) or init (whole pool free).
//   Each request gives exactly one result item on the output channel
//   (o_out_valid / i_out_stall): granted address, status, used bytes, live count.
//   One item is processed at a time; o_in_stall stays high while it runs.
//   The sequencer walks the tables through one shared ALU:
//     allocate: scans records up to slot R and F free entries, shifting entries on a whole take
//     free: scans records up to slot R and F free entries, shifting entries on merge or insert
//     init or unused opcode: no table walk
//   where R is the record slot reached and F the free entries visited.
//   Pool base and size are written through i_cfg_we/i_cfg_idx/i_cfg_data and take
//   effect at the next init. Reset loads the reset pool (base 0, 65536 bytes) in the
//   boot state and clears all records. The result waits in an output register while the
//   receiver stalls; the next request is taken meanwhile, and its result waits
//   until the register frees.
module first_fit_coalescing_allocator #(
    parameter int FREE_SLOTS   = ffca_pkg::DEF_FREE_SLOTS,
    parameter int RECORD_SLOTS = ffca_pkg::DEF_RECORD_SLOTS,
    parameter int HEADER_BYTES = ffca_pkg::DEF_HEADER_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ffca_pkg::LEN_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ffca_pkg::OP_W-1:0]       i_opcode,
    input  logic [ffca_pkg::LEN_W-1:0]      i_request_size,
    input  logic [ffca_pkg::LG_W-1:0]       i_align_log2,
    input  logic [ffca_pkg::ADDR_W-1:0]     i_address,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ffca_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [ffca_pkg::STAT_W-1:0]     o_status,
    output logic [ffca_pkg::LEN_W-1:0]      o_used_bytes,
    output logic [ffca_pkg::LIVE_OUT_W-1:0] o_live_allocations
);
    import ffca_pkg::*;

    logic [ADDR_W-1:0] r_pool_base;
    logic [LEN_W-1:0]  r_pool_size;
    logic              r_out_valid;
    t_rsp              r_out;
    t_req              req;
    t_rsp              rsp;
    logic              core_idle, core_done, load;

    assign req.op   = t_op'(i_opcode);
    assign req.size = i_request_size;
    assign req.lg   = i_align_log2;
    assign req.addr = i_address;

    assign load = core_done && (!r_out_valid || !i_out_stall);

    ffca_seq #(
        .FREE_SLOTS   (FREE_SLOTS),
        .RECORD_SLOTS (RECORD_SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_base (r_pool_base),
        .i_pool_size (r_pool_size),
        .i_start     (i_in_valid && core_idle),
        .i_req       (req),
        .o_idle      (core_idle),
        .o_done      (core_done),
        .i_ack       (load),
        .o_rsp       (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= POOL_BASE_RST;
            r_pool_size <= POOL_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POOL_BASE: r_pool_base <= i_cfg_data;
                CFG_POOL_SIZE: r_pool_size <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= rsp;
    end

    assign o_in_stall         = !core_idle;
    assign o_out_valid        = r_out_valid;
    assign o_granted_address  = r_out.granted;
    assign o_status           = r_out.status;
    assign o_used_bytes       = r_out.used;
    assign o_live_allocations = r_out.live;

endmodule

// ===== hdl/ffca_alu.sv =====
// Shared adder/subtractor used for the sequencer's address sums, length sums and free-table compares.
module ffca_alu (
    input  logic [ffca_pkg::ALU_W-1:0] i_a,
    input  logic [ffca_pkg::ALU_W-1:0] i_b,
    input  ffca_pkg::t_alu_op          i_op,
    output logic [ffca_pkg::ALU_W:0]   o_res
);
    import ffca_pkg::*;

    // top bit is carry on add, borrow on subtract
    always_comb begin
        case (i_op)
            ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
            default: o_res = '0;
        endcase
    end

endmodule

// ===== hdl/ffca_seq.sv =====
// Sequencer with the free table, record table and shared ALU of the allocator.
module ffca_seq #(
    parameter int FREE_SLOTS   = ffca_pkg::DEF_FREE_SLOTS,
    parameter int RECORD_SLOTS = ffca_pkg::DEF_RECORD_SLOTS,
    parameter int HEADER_BYTES = ffca_pkg::DEF_HEADER_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ffca_pkg::ADDR_W-1:0] i_pool_base,
    input  logic [ffca_pkg::LEN_W-1:0]  i_pool_size,
    input  logic                        i_start,
    input  ffca_pkg::t_req              i_req,
    output logic                        o_idle,
    output logic                        o_done,
    input  logic                        i_ack,
    output ffca_pkg::t_rsp              o_rsp
);
    import ffca_pkg::*;

    localparam int CNT_W  = $clog2(FREE_SLOTS + 1);
    localparam int FI_W   = $clog2(FREE_SLOTS);
    localparam int RCNT_W = $clog2(RECORD_SLOTS + 1);
    localparam int RI_W   = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;

    localparam logic [CNT_W-1:0]  FREE_FULL = CNT_W'(FREE_SLOTS);
    localparam logic [RCNT_W-1:0] REC_END   = RCNT_W'(RECORD_SLOTS);
    localparam logic [LEN_W-1:0]  HDR_LEN   = LEN_W'(HEADER_BYTES);
    localparam logic [ADJ_W:0]    HDR_ADJ   = (ADJ_W+1)'(HEADER_BYTES);

    // forward adjustment that aligns a and leaves room for the header
    function automatic logic [ADJ_W-1:0] f_hadj(input logic [ADDR_W-1:0] a,
                                                 input logic [LG_W-1:0] lg);
        logic [ADJ_W:0] al, msk, adj0, need, rnd, sum;
        al   = (ADJ_W+1)'(1) << lg;
        msk  = al - (ADJ_W+1)'(1);
        adj0 = ((ADJ_W+1)'(0) - {1'b0, a[ADJ_W-1:0]}) & msk;
        if (adj0 < HDR_ADJ) begin
            need = HDR_ADJ - adj0;
            rnd  = (need + msk) & ~msk;
            sum  = adj0 + rnd;
        end else begin
            sum  = adj0;
        end
        return sum[ADJ_W-1:0];
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    logic [LEN_W-1:0]  r_size, n_size;
    logic [LG_W-1:0]   r_lg, n_lg;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [RCNT_W-1:0] r_ri, n_ri;
    logic [RI_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]  r_fi, n_fi, r_p, n_p, r_k, n_k, r_free_count, n_free_count;
    logic [ADDR_W-1:0] r_start, n_start, r_bstart, n_bstart, r_bend, n_bend;
    logic [ADDR_W-1:0] r_nstart, n_nstart, r_prev_s, n_prev_s, r_granted, n_granted;
    logic [LEN_W-1:0]  r_len, n_len, r_rem, n_rem, r_bsize, n_bsize, r_nlen, n_nlen;
    logic [LEN_W-1:0]  r_prev_l, n_prev_l, r_tmp, n_tmp, r_used, n_used;
    logic [ALU_W-1:0]  r_total, n_total;
    logic [ADJ_W-1:0]  r_adj, n_adj;
    logic              r_lo, n_lo, r_hi, n_hi;
    t_status           r_status, n_status;
    logic [RCNT_W-1:0] r_live, n_live;
    logic [RECORD_SLOTS-1:0] r_rec_valid, n_rec_valid;

    // table storage
    logic [ADDR_W-1:0] m_fs [FREE_SLOTS];
    logic [LEN_W-1:0]  m_fl [FREE_SLOTS];
    logic [ADDR_W-1:0] m_ra [RECORD_SLOTS];
    logic [LEN_W-1:0]  m_rl [RECORD_SLOTS];
    logic [ADJ_W-1:0]  m_radj [RECORD_SLOTS];
    logic [ADDR_W-1:0] r_fs_rd, r_ra_rd;
    logic [LEN_W-1:0]  r_fl_rd, r_rl_rd;
    logic [ADJ_W-1:0]  r_radj_rd;

    logic              fr_re, fr_we, rc_re, rc_we;
    logic [FI_W-1:0]   fr_raddr, fr_waddr;
    logic [ADDR_W-1:0] fr_wstart;
    logic [LEN_W-1:0]  fr_wlen;
    logic [RI_W-1:0]   rc_raddr;

    logic [ALU_W-1:0]  alu_a, alu_b;
    t_alu_op           alu_op;
    logic [ALU_W:0]    alu_res;
    logic              borrow;

    logic [CNT_W-1:0]  k_inc, k_dec, p_dec;
    logic              rec_here;

    assign k_inc    = r_k + CNT_W'(1);
    assign k_dec    = r_k - CNT_W'(1);
    assign p_dec    = r_p - CNT_W'(1);
    assign borrow   = alu_res[ALU_W];
    assign rec_here = r_rec_valid[r_ri[RI_W-1:0]];

    ffca_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_BOOT:    n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.op)
                        OP_ALLOC: n_state = S_A_CHK;
                        OP_FREE:  n_state = S_F_RREQ;
                        OP_INIT:  n_state = S_INIT;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_A_CHK:   n_state = (r_size == '0) ? S_DONE : S_A_REC;
            S_A_REC: begin
                if (r_ri == REC_END) n_state = S_DONE;
                else if (!rec_here)  n_state = S_A_RD;
            end
            S_A_RD:    n_state = (r_fi == r_free_count) ? S_DONE : S_A_ADJ;
            S_A_ADJ:   n_state = S_A_TOT;
            S_A_TOT:   n_state = S_A_CMP;
            S_A_CMP:   n_state = borrow ? S_A_RD : S_A_REM;
            S_A_REM:   n_state = (r_rem <= HDR_LEN) ? S_SH_RD : S_A_GRANT;
            S_A_GRANT: n_state = S_A_USED;
            S_A_USED:  n_state = S_DONE;
            S_SH_RD:   n_state = (k_inc >= r_free_count) ? r_ret : S_SH_WR;
            S_SH_WR:   n_state = S_SH_RD;
            S_F_RREQ: begin
                if (r_ri == REC_END) n_state = S_DONE;
                else if (rec_here)   n_state = S_F_RCHK;
            end
            S_F_RCHK:  n_state = (r_ra_rd == r_addr) ? S_F_BST : S_F_RREQ;
            S_F_BST:   n_state = S_F_BEND;
            S_F_BEND:  n_state = S_F_PRD;
            S_F_PRD:   n_state = (r_p == r_free_count) ? S_F_LO : S_F_PCHK;
            S_F_PCHK:  n_state = borrow ? S_F_PRD : S_F_LO;
            S_F_LO:    n_state = S_F_MRG;
            S_F_MRG: begin
                if (r_lo && r_hi)               n_state = S_F_M2;
                else if (r_lo || r_hi)          n_state = S_F_FIN;
                else if (r_free_count == FREE_FULL) n_state = S_DONE;
                else                            n_state = S_I_RD;
            end
            S_F_M2:    n_state = S_SH_RD;
            S_I_RD:    n_state = (r_k == r_p) ? S_F_FIN : S_I_WR;
            S_I_WR:    n_state = S_I_RD;
            S_F_FIN:   n_state = S_DONE;
            S_INIT:    n_state = S_DONE;
            S_DONE:    n_state = i_ack ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath, ALU operands and table ports
    always_comb begin
        n_ret = r_ret;   n_size = r_size;   n_lg = r_lg;
        n_addr = r_addr; n_ri = r_ri;     n_slot = r_slot;   n_fi = r_fi;
        n_p = r_p;       n_k = r_k;       n_free_count = r_free_count;
        n_start = r_start;   n_bstart = r_bstart; n_bend = r_bend;
        n_nstart = r_nstart; n_prev_s = r_prev_s; n_granted = r_granted;
        n_len = r_len;   n_rem = r_rem;   n_bsize = r_bsize; n_nlen = r_nlen;
        n_prev_l = r_prev_l; n_tmp = r_tmp; n_used = r_used; n_total = r_total;
        n_adj = r_adj;   n_lo = r_lo;     n_hi = r_hi;       n_status = r_status;
        n_live = r_live; n_rec_valid = r_rec_valid;
        fr_re = 1'b0;    fr_raddr = '0;   fr_we = 1'b0;      fr_waddr = '0;
        fr_wstart = '0;  fr_wlen = '0;    rc_re = 1'b0;      rc_raddr = '0;
        rc_we = 1'b0;
        alu_a = '0;      alu_b = '0;      alu_op = ALU_ADD;

        case (r_state)
            S_BOOT, S_INIT: begin
                fr_we        = 1'b1;
                fr_wstart    = i_pool_base;
                fr_wlen      = i_pool_size;
                n_free_count = CNT_W'(1);
                n_used       = '0;
                n_live       = '0;
                n_rec_valid  = '0;
                n_granted    = '0;
                n_status     = STAT_OK;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_size    = i_req.size;
                    n_lg      = (i_req.lg > LG_W'(ALIGN_MAX)) ? LG_W'(ALIGN_MAX) : i_req.lg;
                    n_addr    = i_req.addr;
                    n_ri      = '0;
                    n_granted = '0;
                    n_status  = STAT_OK;
                end
            end
            S_A_CHK: begin
                if (r_size == '0) n_status = STAT_NOFIT;
            end
            S_A_REC: begin
                if (r_ri == REC_END) begin
                    n_status = STAT_FULL;
                end else if (!rec_here) begin
                    n_slot = r_ri[RI_W-1:0];
                    n_fi   = '0;
                end else begin
                    n_ri = r_ri + RCNT_W'(1);
                end
            end
            S_A_RD: begin
                if (r_fi == r_free_count) begin
                    n_status = STAT_NOFIT;
                end else begin
                    fr_re    = 1'b1;
                    fr_raddr = r_fi[FI_W-1:0];
                end
            end
            S_A_ADJ: begin
                n_start = r_fs_rd;
                n_len   = r_fl_rd;
                n_adj   = f_hadj(r_fs_rd, r_lg);
            end
            S_A_TOT: begin
                alu_a   = ALU_W'(r_size);
                alu_b   = ALU_W'(r_adj);
                n_total = alu_res[ALU_W-1:0];
            end
            S_A_CMP: begin
                alu_a  = ALU_W'(r_len);
                alu_b  = r_total;
                alu_op = ALU_SUB;
                if (borrow) n_fi  = r_fi + CNT_W'(1);
                else        n_rem = alu_res[LEN_W-1:0];
            end
            S_A_REM: begin
                if (r_rem <= HDR_LEN) begin
                    // remainder too small to keep: take the whole block
                    n_total = ALU_W'(r_len);
                    n_k     = r_fi;
                    n_ret   = S_A_GRANT;
                end else begin
                    alu_a     = ALU_W'(r_start);
                    alu_b     = r_total;
                    fr_we     = 1'b1;
                    fr_waddr  = r_fi[FI_W-1:0];
                    fr_wstart = alu_res[ADDR_W-1:0];
                    fr_wlen   = r_rem;
                end
            end
            S_A_GRANT: begin
                alu_a               = ALU_W'(r_start);
                alu_b               = ALU_W'(r_adj);
                n_granted           = alu_res[ADDR_W-1:0];
                rc_we               = 1'b1;
                n_rec_valid[r_slot] = 1'b1;
            end
            S_A_USED: begin
                alu_a  = ALU_W'(r_used);
                alu_b  = r_total;
                n_used = alu_res[LEN_W-1:0];
                n_live = r_live + RCNT_W'(1);
            end
            S_SH_RD: begin
                if (k_inc >= r_free_count) begin
                    n_free_count = r_free_count - CNT_W'(1);
                end else begin
                    fr_re    = 1'b1;
                    fr_raddr = k_inc[FI_W-1:0];
                end
            end
            S_SH_WR: begin
                fr_we     = 1'b1;
                fr_waddr  = r_k[FI_W-1:0];
                fr_wstart = r_fs_rd;
                fr_wlen   = r_fl_rd;
                n_k       = k_inc;
            end
            S_F_RREQ: begin
                if (r_ri == REC_END) begin
                    n_status = STAT_UNKNOWN;
                end else if (!rec_here) begin
                    n_ri = r_ri + RCNT_W'(1);
                end else begin
                    rc_re    = 1'b1;
                    rc_raddr = r_ri[RI_W-1:0];
                end
            end
            S_F_RCHK: begin
                if (r_ra_rd == r_addr) begin
                    n_slot  = r_ri[RI_W-1:0];
                    n_bsize = r_rl_rd;
                    n_adj   = r_radj_rd;
                end else begin
                    n_ri = r_ri + RCNT_W'(1);
                end
            end
            S_F_BST: begin
                alu_a    = ALU_W'(r_addr);
                alu_b    = ALU_W'(r_adj);
                alu_op   = ALU_SUB;
                n_bstart = alu_res[ADDR_W-1:0];
            end
            S_F_BEND: begin
                alu_a  = ALU_W'(r_bstart);
                alu_b  = ALU_W'(r_bsize);
                n_bend = alu_res[ADDR_W-1:0];
                n_p    = '0;
            end
            S_F_PRD: begin
                if (r_p != r_free_count) begin
                    fr_re    = 1'b1;
                    fr_raddr = r_p[FI_W-1:0];
                end
            end
            S_F_PCHK: begin
                // first free block at or above the end of the freed block
                alu_a  = ALU_W'(r_fs_rd);
                alu_b  = ALU_W'(r_bend);
                alu_op = ALU_SUB;
                if (!borrow) begin
                    n_nstart = r_fs_rd;
                    n_nlen   = r_fl_rd;
                end else begin
                    n_prev_s = r_fs_rd;
                    n_prev_l = r_fl_rd;
                    n_p      = r_p + CNT_W'(1);
                end
            end
            S_F_LO: begin
                alu_a = ALU_W'(r_prev_s);
                alu_b = ALU_W'(r_prev_l);
                n_lo  = (r_p != '0) && (alu_res[ADDR_W-1:0] == r_bstart);
                n_hi  = (r_p != r_free_count) && (r_nstart == r_bend);
            end
            S_F_MRG: begin
                if (r_lo) begin
                    alu_a = ALU_W'(r_prev_l);
                    alu_b = ALU_W'(r_bsize);
                    n_tmp = alu_res[LEN_W-1:0];
                    if (!r_hi) begin
                        fr_we     = 1'b1;
                        fr_waddr  = p_dec[FI_W-1:0];
                        fr_wstart = r_prev_s;
                        fr_wlen   = alu_res[LEN_W-1:0];
                    end
                end else if (r_hi) begin
                    alu_a     = ALU_W'(r_nlen);
                    alu_b     = ALU_W'(r_bsize);
                    fr_we     = 1'b1;
                    fr_waddr  = r_p[FI_W-1:0];
                    fr_wstart = r_bstart;
                    fr_wlen   = alu_res[LEN_W-1:0];
                end else if (r_free_count == FREE_FULL) begin
                    n_status = STAT_FULL;
                end else begin
                    n_k = r_free_count;
                end
            end
            S_F_M2: begin
                alu_a     = ALU_W'(r_tmp);
                alu_b     = ALU_W'(r_nlen);
                fr_we     = 1'b1;
                fr_waddr  = p_dec[FI_W-1:0];
                fr_wstart = r_prev_s;
                fr_wlen   = alu_res[LEN_W-1:0];
                n_k       = r_p;
                n_ret     = S_F_FIN;
            end
            S_I_RD: begin
                if (r_k == r_p) begin
                    fr_we        = 1'b1;
                    fr_waddr     = r_p[FI_W-1:0];
                    fr_wstart    = r_bstart;
                    fr_wlen      = r_bsize;
                    n_free_count = r_free_count + CNT_W'(1);
                end else begin
                    fr_re    = 1'b1;
                    fr_raddr = k_dec[FI_W-1:0];
                end
            end
            S_I_WR: begin
                fr_we     = 1'b1;
                fr_waddr  = r_k[FI_W-1:0];
                fr_wstart = r_fs_rd;
                fr_wlen   = r_fl_rd;
                n_k       = k_dec;
            end
            S_F_FIN: begin
                alu_a               = ALU_W'(r_used);
                alu_b               = ALU_W'(r_bsize);
                alu_op              = ALU_SUB;
                n_used              = alu_res[LEN_W-1:0];
                n_rec_valid[r_slot] = 1'b0;
                if (r_live != '0) n_live = r_live - RCNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_BOOT;
            r_ret        <= S_IDLE;
            r_free_count <= '0;
            r_used       <= '0;
            r_live       <= '0;
            r_rec_valid  <= '0;
            r_status     <= STAT_OK;
            r_granted    <= '0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_free_count <= n_free_count;
            r_used       <= n_used;
            r_live       <= n_live;
            r_rec_valid  <= n_rec_valid;
            r_status     <= n_status;
            r_granted    <= n_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;   r_lg <= n_lg;     r_addr <= n_addr;
        r_ri <= n_ri;     r_slot <= n_slot;   r_fi <= n_fi;     r_p <= n_p;
        r_k <= n_k;       r_start <= n_start; r_bstart <= n_bstart;
        r_bend <= n_bend; r_nstart <= n_nstart; r_prev_s <= n_prev_s;
        r_len <= n_len;   r_rem <= n_rem;     r_bsize <= n_bsize; r_nlen <= n_nlen;
        r_prev_l <= n_prev_l; r_tmp <= n_tmp; r_total <= n_total; r_adj <= n_adj;
        r_lo <= n_lo;     r_hi <= n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            m_fs[fr_waddr] <= fr_wstart;
            m_fl[fr_waddr] <= fr_wlen;
        end
        if (fr_re) begin
            r_fs_rd <= m_fs[fr_raddr];
            r_fl_rd <= m_fl[fr_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rc_we) begin
            m_ra[r_slot]   <= n_granted;
            m_rl[r_slot]   <= r_total[LEN_W-1:0];
            m_radj[r_slot] <= r_adj;
        end
        if (rc_re) begin
            r_ra_rd   <= m_ra[rc_raddr];
            r_rl_rd   <= m_rl[rc_raddr];
            r_radj_rd <= m_radj[rc_raddr];
        end
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_rsp.granted  = r_granted;
    assign o_rsp.status   = r_status;
    assign o_rsp.used     = r_used;
    assign o_rsp.live     = LIVE_OUT_W'(r_live);

    a_free_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= FREE_FULL)
        else $error("free table count beyond capacity");

    a_live_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_rec_valid) == r_live))
        else $error("live count disagrees with record valid bits");

    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status != STAT_OK) |-> (r_granted == '0))
        else $error("address granted on a failed request");

endmodule

// ===== tb/tb_first_fit_coalescing_allocator.sv =====
// Testbench for the first-fit coalescing allocator: random and directed items against a predictor.
`timescale 1ns / 100ps

module tb_first_fit_coalescing_allocator;
    import ffca_pkg::*;

    localparam int NFREE = DEF_FREE_SLOTS;
    localparam int NREC  = DEF_RECORD_SLOTS;
    localparam int HDR   = DEF_HEADER_BYTES;

    class alloc_scoreboard;
        bit [31:0] fstart [NFREE];
        bit [31:0] flen   [NFREE];
        int        fcount;
        bit [31:0] raddr  [NREC];
        bit [31:0] rlen   [NREC];
        bit [12:0] radj   [NREC];
        bit        rvalid [NREC];
        bit [31:0] used;
        int        live;
        bit [31:0] base_reg = POOL_BASE_RST;
        bit [31:0] size_reg = POOL_SIZE_RST;
        t_rsp      pending_rsp [$];
        int        errors;

        function void pool_init();
            for (int i = 0; i < NFREE; i++) begin
                fstart[i] = 0;
                flen[i] = 0;
            end
            for (int i = 0; i < NREC; i++) begin
                raddr[i] = 0;
                rlen[i] = 0;
                radj[i] = 0;
                rvalid[i] = 0;
            end
            fstart[0] = base_reg;
            flen[0] = size_reg;
            fcount = 1;
            used = 0;
            live = 0;
        endfunction

        function longint unsigned hdr_adjust(bit [31:0] a, int lg);
            longint unsigned al, adj, need;
            al = 64'd1 << lg;
            adj = (al - (a & (al - 1))) & (al - 1);
            if (adj < HDR) begin
                need = HDR - adj;
                adj += al * (need / al);
                if (need % al != 0) adj += al;
            end
            return adj;
        endfunction

        function void drop_free(int i);
            for (int k = i; k + 1 < fcount; k++) begin
                fstart[k] = fstart[k+1];
                flen[k] = flen[k+1];
            end
            if (fcount > 0) fcount--;
        endfunction

        function t_status do_alloc(bit [31:0] size, int lg, output bit [31:0] granted);
            int r;
            longint unsigned adj, total;
            bit [31:0] start;
            granted = 0;
            if (size == 0) return STAT_NOFIT;
            for (r = 0; r < NREC; r++) if (!rvalid[r]) break;
            if (r == NREC) return STAT_FULL;
            for (int i = 0; i < fcount; i++) begin
                start = fstart[i];
                adj = hdr_adjust(start, lg);
                total = size + adj;
                if (flen[i] < total) continue;
                if (flen[i] - total <= HDR) begin
                    total = flen[i];
                    drop_free(i);
                end else begin
                    fstart[i] = start + total[31:0];
                    flen[i] = flen[i] - total[31:0];
                end
                granted = start + adj[31:0];
                rvalid[r] = 1;
                raddr[r] = granted;
                rlen[r] = total[31:0];
                radj[r] = adj[12:0];
                used = used + total[31:0];
                live++;
                return STAT_OK;
            end
            return STAT_NOFIT;
        endfunction

        function t_status do_free(bit [31:0] a);
            int r, p;
            bit [31:0] bstart, bsize, bend, top;
            bit lo, hi;
            for (r = 0; r < NREC; r++) if (rvalid[r] && raddr[r] == a) break;
            if (r == NREC) return STAT_UNKNOWN;
            bsize = rlen[r];
            bstart = a - 32'(radj[r]);
            bend = bstart + bsize;
            for (p = 0; p < fcount; p++) if (fstart[p] >= bend) break;
            lo = 0;
            if (p > 0) begin
                top = fstart[p-1] + flen[p-1];
                lo = (top == bstart);
            end
            hi = (p < fcount) && (fstart[p] == bend);
            if (lo && hi) begin
                flen[p-1] = flen[p-1] + bsize + flen[p];
                drop_free(p);
            end else if (lo) begin
                flen[p-1] = flen[p-1] + bsize;
            end else if (hi) begin
                fstart[p] = bstart;
                flen[p] = flen[p] + bsize;
            end else begin
                if (fcount >= NFREE) return STAT_FULL;
                for (int k = fcount; k > p; k--) begin
                    fstart[k] = fstart[k-1];
                    flen[k] = flen[k-1];
                end
                fstart[p] = bstart;
                flen[p] = bsize;
                fcount++;
            end
            rvalid[r] = 0;
            if (live > 0) live--;
            used = used - bsize;
            return STAT_OK;
        endfunction

        // predict the result of one accepted item and queue it
        function void note_item(t_req rq);
            t_rsp e;
            int lg;
            e.granted = 0;
            e.status = STAT_OK;
            lg = (rq.lg > ALIGN_MAX) ? ALIGN_MAX : int'(rq.lg);
            case (rq.op)
                OP_ALLOC: e.status = do_alloc(rq.size, lg, e.granted);
                OP_FREE:  e.status = do_free(rq.addr);
                OP_INIT:  pool_init();
                default: ;
            endcase
            e.used = used;
            e.live = LIVE_OUT_W'(live);
            pending_rsp.push_back(e);
        endfunction

        function void check_result(t_rsp got);
            t_rsp e;
            if (pending_rsp.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (got.granted !== e.granted) begin
                $error("granted_address: expected %h actual %h", e.granted, got.granted);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.used !== e.used) begin
                $error("used_bytes: expected %0d actual %0d", e.used, got.used);
                errors++;
            end
            if (got.live !== e.live) begin
                $error("live_allocations: expected %0d actual %0d", e.live, got.live);
                errors++;
            end
        endfunction

        // address of some live allocation, if any
        function bit live_addr(output bit [31:0] a);
            int start;
            a = 0;
            start = $urandom_range(0, NREC - 1);
            for (int k = 0; k < NREC; k++)
                if (rvalid[(start + k) % NREC]) begin
                    a = raddr[(start + k) % NREC];
                    return 1;
                end
            return 0;
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [LEN_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_opcode;
    logic [LEN_W-1:0]      i_request_size;
    logic [LG_W-1:0]       i_align_log2;
    logic [ADDR_W-1:0]     i_address;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [ADDR_W-1:0]     o_granted_address;
    logic [STAT_W-1:0]     o_status;
    logic [LEN_W-1:0]      o_used_bytes;
    logic [LIVE_OUT_W-1:0] o_live_allocations;

    alloc_scoreboard sb;
    bit in_burst;
    bit out_burst;

    first_fit_coalescing_allocator dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic send_item(t_op op, bit [31:0] size, bit [3:0] lg, bit [31:0] a);
        t_req rq;
        int gap;
        gap = draw_gap(in_burst);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_opcode <= op;
        i_request_size <= size;
        i_align_log2 <= lg;
        i_address <= a;
        // stall is settled mid-cycle; the item is taken at the next rising edge
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        rq.op = op;
        rq.size = size;
        rq.lg = lg;
        rq.addr = a;
        sb.note_item(rq);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        if (idx == CFG_POOL_BASE) sb.base_reg = val;
        else sb.size_reg = val;
    endtask

    task automatic wait_drained();
        i_in_valid <= 0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_item();
        int pick;
        bit [31:0] a, size;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) size = $urandom_range(1, 512);
            else if (pick < 9) size = $urandom_range(1, 8192);
            else size = $urandom;
            send_item(OP_ALLOC, size, 4'($urandom_range(0, 15)), 32'($urandom));
        end else if (pick < 88) begin
            if (!sb.live_addr(a) || $urandom_range(0, 9) == 0) a = $urandom;
            send_item(OP_FREE, 32'($urandom), 4'($urandom), a);
        end else if (pick < 93) begin
            send_item(OP_INIT, 32'($urandom), 4'($urandom), 32'($urandom));
        end else begin
            send_item(OP_NOP, 32'($urandom), 4'($urandom), 32'($urandom));
        end
    endtask

    // receiver: random stall before each result
    initial begin
        t_rsp got;
        int gap;
        i_out_stall = 1;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap(out_burst);
            if (gap > 0) begin
                i_out_stall <= 1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 0;
            // sample mid-cycle; the item is taken at the next rising edge
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            got.granted = o_granted_address;
            got.status = t_status'(o_status);
            got.used = o_used_bytes;
            got.live = o_live_allocations;
            sb.check_result(got);
            @(posedge i_clk);
        end
    end

    initial begin
        bit [31:0] a;
        bit [31:0] bases [5] = '{32'h0, 32'h0, 32'hFFFF_FFF0, 32'hFFFF_F000, 32'h0};
        bit [31:0] sizes [5] = '{32'd65536, 32'hFFFF_FFFF, 32'd16, 32'h2000, 32'd0};
        sb = new();
        sb.pool_init();
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_POOL_BASE;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_opcode = OP_NOP;
        i_request_size = 0;
        i_align_log2 = 0;
        i_address = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: edge cases on the reset pool
        send_item(OP_ALLOC, 32'd0, 4'd0, 32'd0);
        send_item(OP_ALLOC, 32'hFFFF_FFFF, 4'd0, 32'hFFFF_FFFF);
        send_item(OP_NOP, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_FREE, 32'd0, 4'd0, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 32'd1, 4'd0, 32'd0);
        send_item(OP_ALLOC, 32'd100, 4'd12, 32'd0);
        send_item(OP_ALLOC, 32'd3, 4'd15, 32'd0);
        send_item(OP_ALLOC, 32'd7, 4'd13, 32'd0);
        for (int i = 0; i < 10; i++) send_item(OP_ALLOC, 32'd1, 4'(i % 4), 32'd0);
        send_item(OP_ALLOC, 32'd1, 4'd0, 32'd0);       // record table still has free slots
        for (int i = 0; i < 5; i++)
            if (sb.live_addr(a)) send_item(OP_FREE, 32'd0, 4'd0, a);
        send_item(OP_INIT, 32'd0, 4'd0, 32'd0);

        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            if (ph == 4) begin
                sizes[4] = $urandom_range(16, 4096);
                bases[4] = $urandom;
            end
            write_reg(CFG_POOL_BASE, bases[ph]);
            write_reg(CFG_POOL_SIZE, sizes[ph]);
            send_item(OP_INIT, 32'($urandom), 4'($urandom), 32'($urandom));
            for (int n = 0; n < 400; n++) begin
                if (n % 100 == 0) begin
                    in_burst = ($urandom_range(0, 2) == 0);
                    out_burst = ($urandom_range(0, 2) == 0);
                end
                random_item();
            end
        end
        in_burst = 0;
        out_burst = 0;
        wait_drained();
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

endmodule
